// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define KNNV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define KNNV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/knnv_pkg.sv -----
// Types and constants shared by the k-nearest-neighbour classifier modules.
`default_nettype none
package knnv_pkg;

    localparam int ELEM_W      = 24;
    localparam int FIELD_LANES = 4;
    localparam int DIST_W      = 33;
    localparam int LABEL_W     = 4;
    localparam int NCOUNT_W    = 3;

    localparam logic [1:0] ACT_QUERY = 2'd0;
    localparam logic [1:0] ACT_REF   = 2'd1;
    localparam logic [1:0] ACT_VOTE  = 2'd2;

    localparam logic [2:0] REG_NEIGHBOR_COUNT_ADDR = 3'd0;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [ELEM_W-1:0] lane0_value;
        logic signed [ELEM_W-1:0] lane1_value;
        logic signed [ELEM_W-1:0] lane2_value;
        logic signed [ELEM_W-1:0] lane3_value;
        logic [LABEL_W-1:0]       ref_label;
        logic                     last_chunk;
    } in_item_t;

    typedef struct packed {
        logic [LABEL_W-1:0] predicted_class;
        logic [2:0]         neighbors_found;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic ref_start;
        logic acc;
        logic ins;
        logic vote_start;
        logic vote_step;
        logic vote_finish;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic vote_done;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

// ----- src/knnv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module knnv_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  wire logic                                           clk,
    input  wire logic                                           we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]                               wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic      [WIDTH-1:0]                               rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- src/knnv_ctrl.sv -----
// Controller state machine sequencing loads, distance steps, insertion and voting.
`default_nettype none
module knnv_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [1:0]       action,
    input  wire knnv_pkg::status_t status,
    output knnv_pkg::cmd_t        cmd,
    output logic                  in_stall
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_INS  = 3'd2;
    localparam logic [2:0] ST_VOTE = 3'd3;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        knnv_pkg::ACT_QUERY: cmd.load = 1'b1;
                        knnv_pkg::ACT_REF:
                        begin
                            cmd.ref_start = 1'b1;
                            state_next    = ST_ACC;
                        end
                        knnv_pkg::ACT_VOTE:
                        begin
                            cmd.vote_start = 1'b1;
                            state_next     = ST_VOTE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.last ? ST_INS : ST_IDLE;
            end
            ST_INS:
            begin
                cmd.ins    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_VOTE:
            begin
                if (!status.vote_done)
                begin
                    cmd.vote_step = 1'b1;
                end
                else if (!status.out_busy)
                begin
                    // The last class is weighed in the same cycle as the result is stored.
                    cmd.vote_finish = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- src/knnv_dp.sv -----
// Datapath: query memory, L1 distance accumulator, sorted neighbour list and vote counter.
`default_nettype none
module knnv_dp #(
    parameter int VECTOR_LENGTH = 256,
    parameter int LANES         = 4,
    parameter int MAX_NEIGHBORS = 7,
    parameter int CLASS_COUNT   = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire knnv_pkg::cmd_t        cmd,
    input  wire knnv_pkg::in_item_t    in_item,
    input  wire logic [2:0]            neighbor_count,
    input  wire logic                  out_stall,
    output knnv_pkg::status_t          status,
    output logic                       out_valid,
    output knnv_pkg::out_item_t        out_item
);
    localparam int EW     = knnv_pkg::ELEM_W;
    localparam int DW     = knnv_pkg::DIST_W;
    localparam int LW     = knnv_pkg::LABEL_W;
    localparam int CHUNKS = (VECTOR_LENGTH + LANES - 1) / LANES;
    localparam int PW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int IW     = $clog2(CHUNKS * LANES + 1) + 1;
    localparam int RW     = LANES * EW;
    localparam int SW     = EW + 1 + $clog2(LANES + 1);
    localparam int KW     = $clog2(MAX_NEIGHBORS + 1);
    localparam int JW     = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CW     = $clog2(MAX_NEIGHBORS + 1);
    localparam int VW     = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam logic [DW-1:0] DIST_MAX = {DW{1'b1}};

    logic [PW-1:0]  ptr_reg, ptr_next;
    logic [PW-1:0]  ptr_q_reg;
    logic [RW-1:0]  ref_row_reg;
    logic [LW-1:0]  label_q_reg;
    logic           last_q_reg;
    logic [DW-1:0]  acc_reg, acc_next;
    logic [DW-1:0]  bd_reg [MAX_NEIGHBORS];
    logic [DW-1:0]  bd_next [MAX_NEIGHBORS];
    logic [LW-1:0]  bl_reg [MAX_NEIGHBORS];
    logic [LW-1:0]  bl_next [MAX_NEIGHBORS];
    logic [MAX_NEIGHBORS-1:0] bv_reg, bv_next;
    logic [VW-1:0]  vcnt_reg;
    logic [CW-1:0]  best_cnt_reg;
    logic [LW-1:0]  pred_reg;
    logic           out_valid_reg;
    knnv_pkg::out_item_t out_item_reg;

    logic [EW-1:0]  fld [knnv_pkg::FIELD_LANES];
    logic [RW-1:0]  in_row;
    logic [RW-1:0]  q_row;
    logic [SW-1:0]  chunk_sum;
    logic [DW:0]    acc_wide;
    logic [KW-1:0]  k_eff;
    logic [JW-1:0]  km1;
    logic [MAX_NEIGHBORS-1:0] le;
    logic           ins_ok;
    logic [CW-1:0]  class_cnt;
    logic [CW-1:0]  found_cnt;
    logic [LW-1:0]  pred_final;

    assign fld[0] = in_item.lane0_value;
    assign fld[1] = in_item.lane1_value;
    assign fld[2] = in_item.lane2_value;
    assign fld[3] = in_item.lane3_value;

    always_comb
    begin
        in_row = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (i < knnv_pkg::FIELD_LANES)
            begin
                in_row[i*EW +: EW] = fld[i % knnv_pkg::FIELD_LANES];
            end
        end
    end

    knnv_ram #(
        .WIDTH(RW),
        .DEPTH(CHUNKS)
    ) u_query_ram (
        .clk  (clk),
        .we   (cmd.load),
        .waddr(ptr_reg),
        .wdata(in_row),
        .raddr(ptr_reg),
        .rdata(q_row)
    );

    // One pointer serves query and reference chunks.
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load || cmd.ref_start)
        begin
            if (in_item.last_chunk || ptr_reg == PW'(CHUNKS - 1))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ref_start)
        begin
            ptr_q_reg   <= ptr_reg;
            ref_row_reg <= in_row;
            label_q_reg <= in_item.ref_label;
            last_q_reg  <= in_item.last_chunk;
        end
    end

    always_comb
    begin
        logic signed [EW:0] d;
        logic [IW-1:0]      idx;
        chunk_sum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            idx = IW'(ptr_q_reg) * IW'(LANES) + IW'(i);
            d   = $signed({q_row[i*EW + EW - 1], q_row[i*EW +: EW]})
                - $signed({ref_row_reg[i*EW + EW - 1], ref_row_reg[i*EW +: EW]});
            if (idx < IW'(VECTOR_LENGTH))
            begin
                chunk_sum = chunk_sum + SW'(d[EW] ? $unsigned(-d) : $unsigned(d));
            end
        end
        acc_wide = {1'b0, acc_reg} + (DW + 1)'(chunk_sum);
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc)
        begin
            acc_next = acc_wide[DW] ? DIST_MAX : acc_wide[DW-1:0];
        end
        else if (cmd.ins)
        begin
            acc_next = '0;
        end
    end

    always_comb
    begin
        if (neighbor_count == 3'd0)
        begin
            k_eff = KW'(1);
        end
        else if (int'(neighbor_count) > MAX_NEIGHBORS)
        begin
            k_eff = KW'(MAX_NEIGHBORS);
        end
        else
        begin
            k_eff = KW'(neighbor_count);
        end
        km1 = JW'(k_eff - 1'b1);
    end

    // le marks the leading run of valid entries at or below the new distance; entries
    // left from a larger K need not be sorted, so the run stops at the first miss.
    always_comb
    begin
        logic run;
        run = 1'b1;
        for (int j = 0; j < MAX_NEIGHBORS; j++)
        begin
            run   = run && bv_reg[j] && (bd_reg[j] <= acc_reg);
            le[j] = run;
        end
        ins_ok = !bv_reg[km1] || (acc_reg < bd_reg[km1]);
    end

    always_comb
    begin
        bd_next = bd_reg;
        bl_next = bl_reg;
        bv_next = bv_reg;
        if (cmd.vote_finish)
        begin
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                bd_next[j] = DIST_MAX;
                bl_next[j] = '0;
                bv_next[j] = 1'b0;
            end
        end
        else if (cmd.ins && ins_ok)
        begin
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                if (j <= int'(km1))
                begin
                    if (j < int'(km1) && le[j])
                    begin
                        bd_next[j] = bd_reg[j];
                    end
                    else if (j == 0)
                    begin
                        bd_next[j] = acc_reg;
                        bl_next[j] = label_q_reg;
                        bv_next[j] = 1'b1;
                    end
                    else if (le[j-1])
                    begin
                        bd_next[j] = acc_reg;
                        bl_next[j] = label_q_reg;
                        bv_next[j] = 1'b1;
                    end
                    else
                    begin
                        bd_next[j] = bd_reg[j-1];
                        bl_next[j] = bl_reg[j-1];
                        bv_next[j] = bv_reg[j-1];
                    end
                end
            end
        end
    end

    // Votes for the class under the counter, and the number of voting entries.
    always_comb
    begin
        class_cnt = '0;
        found_cnt = '0;
        for (int j = 0; j < MAX_NEIGHBORS; j++)
        begin
            if (j < int'(k_eff) && bv_reg[j])
            begin
                if ({1'b0, bl_reg[j]} < (LW + 1)'(CLASS_COUNT))
                begin
                    found_cnt = found_cnt + 1'b1;
                end
                if ({1'b0, bl_reg[j]} == (LW + 1)'(vcnt_reg))
                begin
                    class_cnt = class_cnt + 1'b1;
                end
            end
        end
        pred_final = (class_cnt > best_cnt_reg) ? LW'(vcnt_reg) : pred_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.vote_start)
        begin
            vcnt_reg     <= '0;
            best_cnt_reg <= '0;
            pred_reg     <= '0;
        end
        else if (cmd.vote_step)
        begin
            vcnt_reg <= vcnt_reg + 1'b1;
            if (class_cnt > best_cnt_reg)
            begin
                best_cnt_reg <= class_cnt;
                pred_reg     <= LW'(vcnt_reg);
            end
        end
        if (cmd.vote_finish)
        begin
            out_item_reg.predicted_class <= pred_final;
            out_item_reg.neighbors_found <= 3'(found_cnt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            acc_reg       <= '0;
            bv_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                bd_reg[j] <= DIST_MAX;
                bl_reg[j] <= '0;
            end
        end
        else
        begin
            ptr_reg <= ptr_next;
            acc_reg <= acc_next;
            bv_reg  <= bv_next;
            bd_reg  <= bd_next;
            bl_reg  <= bl_next;
            if (cmd.vote_finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.last      = last_q_reg;
    assign status.vote_done = (vcnt_reg == VW'(CLASS_COUNT - 1));
    assign status.out_busy  = out_valid_reg && out_stall;
    assign out_valid        = out_valid_reg;
    assign out_item         = out_item_reg;
endmodule
`default_nettype wire

// ----- src/knn_l1_topk_vote.sv -----
// Top level of the k-nearest-neighbour classifier with L1 distance and majority vote.
// A query chunk (action 0) is written without holding the input; for a reference
// chunk (action 1) the stored query row is read from a registered RAM of
// ceil(VECTOR_LENGTH/LANES) rows in the accept cycle and the absolute differences
// are summed in the next. After the last chunk of a reference vector all K list
// entries are compared with its distance in parallel and the list is shifted. A
// vote (action 2) counts the votes of each class in turn, then waits for any
// previous result to leave the output register. Action 3 is taken without a stall
// and gives no result. neighbor_count sits at byte address 0 of the APB port.
`default_nettype none
module knn_l1_topk_vote #(
    parameter int VECTOR_LENGTH = 256,
    parameter int LANES         = 4,
    parameter int MAX_NEIGHBORS = 7,
    parameter int CLASS_COUNT   = 10
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire knnv_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output knnv_pkg::out_item_t      out_item,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    logic [knnv_pkg::NCOUNT_W-1:0] ncount_reg;
    knnv_pkg::cmd_t    cmd;
    knnv_pkg::status_t status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncount_reg <= knnv_pkg::NCOUNT_W'(1);
        end
        else if (psel && penable && pwrite && pready
                 && paddr == knnv_pkg::REG_NEIGHBOR_COUNT_ADDR)
        begin
            ncount_reg <= pwdata[knnv_pkg::NCOUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == knnv_pkg::REG_NEIGHBOR_COUNT_ADDR)
        begin
            prdata = 32'(ncount_reg);
        end
    end

    knnv_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .action  (in_item.action),
        .status  (status),
        .cmd     (cmd),
        .in_stall(in_stall)
    );

    knnv_dp #(
        .VECTOR_LENGTH(VECTOR_LENGTH),
        .LANES        (LANES),
        .MAX_NEIGHBORS(MAX_NEIGHBORS),
        .CLASS_COUNT  (CLASS_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_item       (in_item),
        .neighbor_count(ncount_reg),
        .out_stall     (out_stall),
        .status        (status),
        .out_valid     (out_valid),
        .out_item      (out_item)
    );
endmodule
`default_nettype wire

// ----- src/knnv_checker.sv -----
// Port-level checker for the classifier and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module knnv_checker #(
    parameter int CLASS_COUNT = 10
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire knnv_pkg::in_item_t  in_item,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire knnv_pkg::out_item_t out_item
);
    logic vote_taken;
    assign vote_taken = in_valid && !in_stall && in_item.action == knnv_pkg::ACT_VOTE;

    // A stalled result transaction holds its value.
    `KNNV_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
    `KNNV_ASSERT_IMP(a_class_range, out_valid,
        {1'b0, out_item.predicted_class} < 5'(CLASS_COUNT))
    `KNNV_ASSERT_NXT(a_vote_busy, vote_taken, in_stall)
    // A new result only appears at the end of a vote, while the input side is held.
    `KNNV_ASSERT_IMP(a_result_in_vote, $rose(out_valid), $past(in_stall))
endmodule

bind knn_l1_topk_vote knnv_checker #(
    .CLASS_COUNT(CLASS_COUNT)
) u_knnv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
);
`default_nettype wire

// ----- tb/knn_l1_topk_vote_tb.sv -----
// Self-checking testbench for the k-nearest-neighbour L1 classifier with majority vote.
`default_nettype none
module knn_l1_topk_vote_tb;

    localparam int VLEN    = 256;
    localparam int NLANES  = 4;
    localparam int MAXK    = 7;
    localparam int NCLASS  = 10;
    localparam int NCHUNKS = (VLEN + NLANES - 1) / NLANES;
    localparam logic [knnv_pkg::DIST_W-1:0] DIST_SAT = {knnv_pkg::DIST_W{1'b1}};
    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    knnv_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    knnv_pkg::out_item_t out_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    knn_l1_topk_vote dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    // Classifier state mirrored by the predictor.
    logic [2:0]                  k_reg;
    logic [knnv_pkg::ELEM_W-1:0] query_mem [VLEN];
    int                          chunk_pos;
    logic [knnv_pkg::DIST_W-1:0] dist_sum;
    logic [knnv_pkg::DIST_W-1:0] nn_dist [MAXK];
    logic [3:0]                  nn_label [MAXK];
    bit                          nn_valid [MAXK];

    knnv_pkg::out_item_t votes_due[$];
    int  mismatches = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  hold_cycles = 0;

    function automatic int eff_k();
        if (k_reg == 0) return 1;
        if (k_reg > MAXK) return MAXK;
        return int'(k_reg);
    endfunction

    task automatic clear_neighbours();
        for (int j = 0; j < MAXK; j++)
        begin
            nn_dist[j] = DIST_SAT;
            nn_label[j] = '0;
            nn_valid[j] = 1'b0;
        end
    endtask

    task automatic step_pointer(input bit last);
        if (last || chunk_pos + 1 >= NCHUNKS) chunk_pos = 0;
        else chunk_pos++;
    endtask

    task automatic insert_neighbour(input logic [knnv_pkg::DIST_W-1:0] d,
                                    input logic [3:0] lbl);
        int k;
        int pos;
        k = eff_k();
        if (nn_valid[k-1] && !(d < nn_dist[k-1])) return;
        pos = 0;
        while (pos < k - 1 && nn_valid[pos] && nn_dist[pos] <= d) pos++;
        for (int j = k - 1; j > pos; j--)
        begin
            nn_dist[j] = nn_dist[j-1];
            nn_label[j] = nn_label[j-1];
            nn_valid[j] = nn_valid[j-1];
        end
        nn_dist[pos] = d;
        nn_label[pos] = lbl;
        nn_valid[pos] = 1'b1;
    endtask

    // Applies one accepted transaction and queues the vote it produces, if any.
    task automatic predict_classifier(input knnv_pkg::in_item_t it);
        logic signed [knnv_pkg::ELEM_W-1:0] lanes [NLANES];
        longint diff;
        longint acc;
        int votes [NCLASS];
        int found;
        int pred;
        knnv_pkg::out_item_t r;
        lanes[0] = it.lane0_value;
        lanes[1] = it.lane1_value;
        lanes[2] = it.lane2_value;
        lanes[3] = it.lane3_value;
        case (it.action)
            knnv_pkg::ACT_QUERY:
            begin
                for (int i = 0; i < NLANES; i++)
                    query_mem[chunk_pos*NLANES+i] = lanes[i];
                step_pointer(it.last_chunk);
            end
            knnv_pkg::ACT_REF:
            begin
                acc = dist_sum;
                for (int i = 0; i < NLANES; i++)
                begin
                    diff = longint'($signed(query_mem[chunk_pos*NLANES+i]))
                         - longint'(lanes[i]);
                    if (diff < 0) diff = -diff;
                    acc += diff;
                    if (acc > longint'(DIST_SAT)) acc = longint'(DIST_SAT);
                end
                dist_sum = acc[knnv_pkg::DIST_W-1:0];
                if (it.last_chunk)
                begin
                    insert_neighbour(dist_sum, it.ref_label);
                    dist_sum = '0;
                end
                step_pointer(it.last_chunk);
            end
            knnv_pkg::ACT_VOTE:
            begin
                found = 0;
                pred = 0;
                for (int c = 0; c < NCLASS; c++) votes[c] = 0;
                for (int i = 0; i < eff_k(); i++)
                    if (nn_valid[i] && nn_label[i] < NCLASS)
                    begin
                        votes[nn_label[i]]++;
                        found++;
                    end
                for (int c = 1; c < NCLASS; c++)
                    if (votes[c] > votes[pred]) pred = c;
                clear_neighbours();
                r.predicted_class = pred[3:0];
                r.neighbors_found = found[2:0];
                votes_due.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input knnv_pkg::out_item_t exp_r,
                                   input knnv_pkg::out_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected class %0d found %0d, got class %0d found %0d",
                     what, exp_r.predicted_class, exp_r.neighbors_found,
                     got.predicted_class, got.neighbors_found);
    endtask

    // Result side: compare each accepted transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (votes_due.size() == 0)
                report_mismatch("unexpected result", '0, out_item);
            else if (out_item !== votes_due[0])
            begin
                report_mismatch("field", votes_due[0], out_item);
                void'(votes_due.pop_front());
            end
            else
                void'(votes_due.pop_front());
        end
    end

    // Receiver stall: a long hold-off when requested, otherwise random.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // The valid line stays high after the transaction is taken; the next idle cycle,
    // the next transaction or the caller's wait drops or replaces it.
    task automatic send_item(input knnv_pkg::in_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_classifier(it);
    endtask

    task automatic drain(input int extra);
        in_valid <= 1'b0;
        while (votes_due.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_k(input logic [2:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= knnv_pkg::REG_NEIGHBOR_COUNT_ADDR;
        pwdata <= {29'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        k_reg = value;
    endtask

    function automatic knnv_pkg::in_item_t make_item(input logic [1:0] act, input int v,
                                                     input logic [3:0] lbl, input bit last);
        knnv_pkg::in_item_t it;
        it.action = act;
        it.lane0_value = 24'(v);
        it.lane1_value = 24'(v);
        it.lane2_value = 24'(v);
        it.lane3_value = 24'(v);
        it.ref_label = lbl;
        it.last_chunk = last;
        return it;
    endfunction

    function automatic knnv_pkg::in_item_t rand_item(input logic [1:0] act, input bit last);
        knnv_pkg::in_item_t it;
        int sel;
        it.action = act;
        sel = $urandom_range(9);
        // Occasional full-scale lanes exercise the saturating sum and the sign bits.
        it.lane0_value = (sel == 0) ? 24'h800000 : (sel == 1) ? 24'h7fffff : 24'($urandom());
        it.lane1_value = 24'($urandom());
        it.lane2_value = (sel < 7) ? 24'($urandom_range(255)) : 24'($urandom());
        it.lane3_value = 24'($urandom());
        it.ref_label = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10))
                                                  : 4'($urandom_range(9));
        it.last_chunk = last;
        return it;
    endfunction

    // Directed stimulus; a known result is typed in where one can be read off directly.
    typedef struct {
        knnv_pkg::in_item_t  item;
        bit                  known;
        knnv_pkg::out_item_t result;
    } directed_row_t;

    task automatic load_full_query(input bit random_vals);
        for (int c = 0; c < NCHUNKS; c++)
            send_item(random_vals ? rand_item(knnv_pkg::ACT_QUERY, c == NCHUNKS - 1)
                                  : make_item(knnv_pkg::ACT_QUERY, 0, 0, c == NCHUNKS - 1));
    endtask

    task automatic random_phase(input int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(19))
                0:
                begin
                    send_item(rand_item(knnv_pkg::ACT_VOTE, 1'($urandom_range(1))));
                    sent++;
                end
                1: begin send_item(rand_item(ACT_SPARE, 1'($urandom_range(1)))); end
                2:
                begin
                    send_item(rand_item(knnv_pkg::ACT_QUERY, 1'($urandom_range(1))));
                    sent++;
                end
                default:
                begin
                    // Short reference vectors keep the neighbour list busy.
                    len = $urandom_range(4, 1);
                    for (int c = 0; c < len; c++)
                        send_item(rand_item(knnv_pkg::ACT_REF, c == len - 1));
                    sent += len;
                    if ($urandom_range(4) == 0)
                    begin
                        send_item(rand_item(knnv_pkg::ACT_VOTE, 0));
                        sent++;
                    end
                end
            endcase
        end
        send_item(rand_item(knnv_pkg::ACT_VOTE, 0));
    endtask

    initial
    begin
        directed_row_t rows[$];
        knnv_pkg::out_item_t none;
        none = '0;
        k_reg = 3'd1;
        chunk_pos = 0;
        dist_sum = '0;
        clear_neighbours();
        for (int i = 0; i < VLEN; i++)
            query_mem[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list after reset votes class 0 with no neighbours.
        rows.push_back('{make_item(knnv_pkg::ACT_VOTE, 0, 0, 0), 1'b1, none});
        rows.push_back('{make_item(ACT_SPARE, -1, 15, 1), 1'b0, none});
        foreach (rows[i])
        begin
            send_item(rows[i].item);
            if (rows[i].known && votes_due[$] != rows[i].result)
                report_mismatch("directed table", rows[i].result, votes_due[$]);
        end
        load_full_query(1'b0);
        rows.delete();
        rows.push_back('{make_item(knnv_pkg::ACT_REF, 8388607, 3, 1), 1'b0, none});
        rows.push_back('{make_item(knnv_pkg::ACT_REF, -8388608, 12, 1), 1'b0, none});
        rows.push_back('{make_item(knnv_pkg::ACT_REF, 0, 9, 1), 1'b0, none});
        rows.push_back('{make_item(knnv_pkg::ACT_VOTE, 0, 0, 0), 1'b0, none});
        foreach (rows[i]) send_item(rows[i].item);
        drain(20);
        write_k(3'd0);
        rows.delete();
        rows.push_back('{make_item(knnv_pkg::ACT_REF, 5, 2, 1), 1'b0, none});
        rows.push_back('{make_item(knnv_pkg::ACT_REF, 5, 4, 1), 1'b0, none});
        rows.push_back('{make_item(knnv_pkg::ACT_VOTE, 0, 0, 0), 1'b0, none});
        foreach (rows[i]) send_item(rows[i].item);
        // Full-scale differences over two wraps of the pointer and one more chunk
        // drive the sum into saturation.
        for (int c = 0; c < NCHUNKS; c++)
            send_item(make_item(knnv_pkg::ACT_QUERY, 8388607, 0, c == NCHUNKS - 1));
        for (int c = 0; c <= 2 * NCHUNKS; c++)
            send_item(make_item(knnv_pkg::ACT_REF, -8388608, 1, c == 2 * NCHUNKS));
        send_item(make_item(knnv_pkg::ACT_VOTE, 0, 0, 0));
        drain(20);

        write_k(3'd7);
        load_full_query(1'b1);
        idle_pct = 0; stall_pct = 0;
        random_phase(80);
        drain(20);
        write_k(3'd3);
        idle_pct = 64;
        random_phase(60);
        drain(20);
        write_k(3'd6);
        idle_pct = 0; stall_pct = 64;
        hold_cycles = 300;
        random_phase(80);
        drain(20);
        write_k(3'd1);
        idle_pct = 24; stall_pct = 24;
        random_phase(80);
        drain(30);

        if (mismatches == 0 && votes_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
